[rtl/core/skpl_pkg.sv]
`timescale 1ns / 1ps
package skpl_pkg;

  localparam int unsigned SampleBits  = 24;
  localparam int unsigned CoefBits    = 24;
  localparam int unsigned MaxChannels = 2;
  localparam int unsigned GainBits    = 20;
  localparam int unsigned MagBits     = 28;
  localparam int unsigned DemandBits  = 24;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [10:0] DbPerLog2Q8  = 11'd1541;
  localparam logic [13:0] Log2PerDbQ16 = 14'd10885;
  localparam logic [16:0] LevelOffset  = 17'd35443;

  typedef enum logic [2:0] {
    CFG_ENABLE  = 3'd0,
    CFG_GAIN    = 3'd1,
    CFG_THRESH  = 3'd2,
    CFG_KNEE_W  = 3'd3,
    CFG_KNEE_S  = 3'd4,
    CFG_ATTACK  = 3'd5,
    CFG_RELEASE = 3'd6,
    CFG_STEREO  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               enable;
    logic [19:0]        gain_factor;
    logic signed [15:0] threshold_db;
    logic [12:0]        knee_width_db;
    logic [15:0]        knee_scale;
    logic [23:0]        attack_coef;
    logic [23:0]        release_coef;
    logic               stereo_mode;
  } cfg_t;

  typedef struct packed {
    logic        bypass;
    logic        ch;
    logic        neg;
    logic [23:0] mag;
    logic [23:0] sample;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GAIN, S_LOG, S_LEVEL, S_SQR, S_SCALE, S_HOLD_M, S_HOLD_S,
    S_PEAK_M, S_PEAK_S, S_ATT, S_EXP, S_DONE
  } back_state_e;

  function automatic logic [7:0] log2_frac(input logic [4:0] f);
    logic [7:0] r;
    unique case (f)
      5'd0: r = 8'd0;     5'd1: r = 8'd11;    5'd2: r = 8'd22;    5'd3: r = 8'd33;
      5'd4: r = 8'd44;    5'd5: r = 8'd54;    5'd6: r = 8'd63;    5'd7: r = 8'd73;
      5'd8: r = 8'd82;    5'd9: r = 8'd92;    5'd10: r = 8'd100;  5'd11: r = 8'd109;
      5'd12: r = 8'd118;  5'd13: r = 8'd126;  5'd14: r = 8'd134;  5'd15: r = 8'd142;
      5'd16: r = 8'd150;  5'd17: r = 8'd157;  5'd18: r = 8'd165;  5'd19: r = 8'd172;
      5'd20: r = 8'd179;  5'd21: r = 8'd186;  5'd22: r = 8'd193;  5'd23: r = 8'd200;
      5'd24: r = 8'd207;  5'd25: r = 8'd213;  5'd26: r = 8'd220;  5'd27: r = 8'd226;
      5'd28: r = 8'd232;  5'd29: r = 8'd238;  5'd30: r = 8'd244;  default: r = 8'd250;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_frac(input logic [4:0] f);
    logic [16:0] r;
    unique case (f)
      5'd0: r = 17'd65536;  5'd1: r = 17'd64132;  5'd2: r = 17'd62757;  5'd3: r = 17'd61413;
      5'd4: r = 17'd60097;  5'd5: r = 17'd58809;  5'd6: r = 17'd57549;  5'd7: r = 17'd56316;
      5'd8: r = 17'd55109;  5'd9: r = 17'd53928;  5'd10: r = 17'd52772; 5'd11: r = 17'd51641;
      5'd12: r = 17'd50535; 5'd13: r = 17'd49452; 5'd14: r = 17'd48392; 5'd15: r = 17'd47355;
      5'd16: r = 17'd46341; 5'd17: r = 17'd45348; 5'd18: r = 17'd44376; 5'd19: r = 17'd43425;
      5'd20: r = 17'd42495; 5'd21: r = 17'd41584; 5'd22: r = 17'd40693; 5'd23: r = 17'd39821;
      5'd24: r = 17'd38968; 5'd25: r = 17'd38133; 5'd26: r = 17'd37316; 5'd27: r = 17'd36516;
      5'd28: r = 17'd35734; 5'd29: r = 17'd34968; 5'd30: r = 17'd34219; default: r = 17'd33486;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/skpl_front.sv]
`timescale 1ns / 1ps
module skpl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skpl_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [23:0]         sample_in_i,
  input  logic                full_i,
  output logic                push_o,
  output skpl_pkg::item_t     item_o
);

  logic next_ch_q, next_ch_d;
  logic neg;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;
  assign neg        = sample_in_i[23];

  always_comb begin
    item_o.bypass = ~cfg_i.enable;
    item_o.ch     = next_ch_q;
    item_o.neg    = neg;
    item_o.mag    = neg ? (~sample_in_i + 24'd1) : sample_in_i;
    item_o.sample = sample_in_i;
  end

  always_comb begin
    next_ch_d = next_ch_q;
    if (push_o && cfg_i.enable) begin
      next_ch_d = cfg_i.stereo_mode ? ~next_ch_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_ch_q <= 1'b0;
    end else begin
      next_ch_q <= next_ch_d;
    end
  end

endmodule

[rtl/core/skpl_fifo.sv]
`timescale 1ns / 1ps
module skpl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  skpl_pkg::item_t item_i,
  input  logic            pop_i,
  output skpl_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);

  skpl_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/core/skpl_back.sv]
`timescale 1ns / 1ps
module skpl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  skpl_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  skpl_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [23:0]     sample_out_o,
  output logic            channel_index_o
);

  skpl_pkg::back_state_e st_q, st_d;
  skpl_pkg::item_t       it_q;

  logic [27:0]        m_q;
  logic [12:0]        l_q;
  logic               zero_q;
  logic signed [17:0] bias_q;
  logic [27:0]        sq_q;
  logic               soft_q;
  logic [23:0]        dem_q;
  logic [47:0]        p1_q;
  logic [48:0]        p2_q;
  logic [21:0]        a_q;
  logic [28:0]        e_q;
  logic [23:0]        hold_q [2];
  logic [23:0]        peak_q [2];

  logic        out_valid_q;
  logic [23:0] out_q;
  logic        out_ch_q;
  logic        load;

  // leading one search
  logic [4:0]  pos;
  logic [27:0] norm;
  always_comb begin
    pos = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (m_q[i]) pos = 5'(i);
    end
    norm = m_q << (5'd27 - pos);
  end

  // level and knee
  logic [23:0]        lprod;
  logic signed [16:0] lv, lvc;
  logic signed [18:0] b2, kn;
  logic [13:0]        t;
  always_comb begin
    lprod = 24'(l_q) * 24'(skpl_pkg::DbPerLog2Q8);
    lv    = $signed({1'b0, lprod[23:8]}) - $signed(skpl_pkg::LevelOffset);
    lvc   = (zero_q || lv < -17'sd32768) ? -17'sd32768 : lv;
    b2    = {bias_q, 1'b0};
    kn    = $signed({6'd0, cfg_i.knee_width_db});
    t     = 14'(b2 + kn);
  end

  logic [48:0] hsum;
  logic [23:0] hnew;
  logic [23:0] mx;
  logic [37:0] aprod;
  logic [44:0] eprod;
  logic [13:0] ip;
  logic [28:0] r;
  logic [23:0] res;
  always_comb begin
    hsum  = {1'b0, p1_q} + p2_q;
    hnew  = (hsum[47:24] < dem_q) ? dem_q : hsum[47:24];
    mx    = (peak_q[0] > peak_q[1]) ? peak_q[0] : peak_q[1];
    aprod = 38'(mx) * 38'(skpl_pkg::Log2PerDbQ16);
    eprod = 45'(m_q) * 45'(skpl_pkg::exp_frac(a_q[7:3]));
    ip    = a_q[21:8];
    r     = (ip >= 14'd29) ? 29'd0 : (e_q >> ip[4:0]);
    if (it_q.bypass) begin
      res = it_q.sample;
    end else if (it_q.neg) begin
      res = (r > 29'h800000) ? 24'h800000 : (~r[23:0] + 24'd1);
    end else begin
      res = (r > 29'h7FFFFF) ? 24'h7FFFFF : r[23:0];
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      skpl_pkg::S_IDLE:   if (!empty_i) st_d = item_i.bypass ? skpl_pkg::S_DONE
                                                             : skpl_pkg::S_GAIN;
      skpl_pkg::S_GAIN:   st_d = skpl_pkg::S_LOG;
      skpl_pkg::S_LOG:    st_d = skpl_pkg::S_LEVEL;
      skpl_pkg::S_LEVEL:  st_d = skpl_pkg::S_SQR;
      skpl_pkg::S_SQR:    st_d = skpl_pkg::S_SCALE;
      skpl_pkg::S_SCALE:  st_d = skpl_pkg::S_HOLD_M;
      skpl_pkg::S_HOLD_M: st_d = skpl_pkg::S_HOLD_S;
      skpl_pkg::S_HOLD_S: st_d = skpl_pkg::S_PEAK_M;
      skpl_pkg::S_PEAK_M: st_d = skpl_pkg::S_PEAK_S;
      skpl_pkg::S_PEAK_S: st_d = skpl_pkg::S_ATT;
      skpl_pkg::S_ATT:    st_d = skpl_pkg::S_EXP;
      skpl_pkg::S_EXP:    st_d = skpl_pkg::S_DONE;
      skpl_pkg::S_DONE:   if (!out_valid_q || !out_stall_i) st_d = skpl_pkg::S_IDLE;
      default:            st_d = skpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (st_q == skpl_pkg::S_IDLE) && !empty_i;
    load  = (st_q == skpl_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= skpl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      hold_q[0]   <= '0;
      hold_q[1]   <= '0;
      peak_q[0]   <= '0;
      peak_q[1]   <= '0;
    end else begin
      st_q <= st_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (st_q == skpl_pkg::S_HOLD_S) hold_q[it_q.ch] <= hnew;
      if (st_q == skpl_pkg::S_PEAK_S) peak_q[it_q.ch] <= hsum[47:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (load) begin
      out_q    <= res;
      out_ch_q <= it_q.ch;
    end
    unique case (st_q)
      skpl_pkg::S_GAIN: begin
        m_q <= 28'((44'(it_q.mag) * 44'(cfg_i.gain_factor)) >> 16);
      end
      skpl_pkg::S_LOG: begin
        zero_q <= m_q == '0;
        l_q    <= {pos, 8'd0} + 13'(skpl_pkg::log2_frac(norm[26:22]));
      end
      skpl_pkg::S_LEVEL: begin
        bias_q <= $signed({lvc[16], lvc}) - $signed({{2{cfg_i.threshold_db[15]}},
                                                     cfg_i.threshold_db});
      end
      skpl_pkg::S_SQR: begin
        soft_q <= 1'b0;
        sq_q   <= 28'(t) * 28'(t);
        if (cfg_i.knee_width_db == '0) begin
          dem_q <= (bias_q > 18'sd0) ? 24'(bias_q[16:0]) : 24'd0;
        end else if (b2 < -kn) begin
          dem_q <= 24'd0;
        end else if (b2 <= kn) begin
          soft_q <= 1'b1;
        end else begin
          dem_q <= 24'(bias_q[16:0]);
        end
      end
      skpl_pkg::S_SCALE: begin
        if (soft_q) dem_q <= 24'((44'(sq_q) * 44'(cfg_i.knee_scale)) >> 24);
      end
      skpl_pkg::S_HOLD_M: begin
        p1_q <= 48'(cfg_i.release_coef) * 48'(hold_q[it_q.ch]);
        p2_q <= 49'({1'b1, 24'd0} - 25'(cfg_i.release_coef)) * 49'(dem_q);
      end
      skpl_pkg::S_PEAK_M: begin
        p1_q <= 48'(cfg_i.attack_coef) * 48'(peak_q[it_q.ch]);
        p2_q <= 49'({1'b1, 24'd0} - 25'(cfg_i.attack_coef)) * 49'(hold_q[it_q.ch]);
      end
      skpl_pkg::S_ATT: a_q <= aprod[37:16];
      skpl_pkg::S_EXP: e_q <= eprod[44:16];
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;
  assign channel_index_o = out_ch_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == skpl_pkg::S_IDLE) else $error("pop outside idle");
  a_hold_ge_demand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == skpl_pkg::S_HOLD_S |=> hold_q[it_q.ch] >= dem_q)
    else $error("release hold below demand");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && st_q == skpl_pkg::S_IDLE) else $error("result lost");

endmodule

[rtl/core/soft_knee_peak_limiter.sv]
`timescale 1ns / 1ps
// A limited sample steps through the back-end sequencer states GAIN, LOG, LEVEL,
// SQR, SCALE, HOLD_M, HOLD_S, PEAK_M, PEAK_S, ATT, EXP and DONE; a pass-through
// sample (disabled) goes from IDLE straight to DONE. The back end works on one
// sample at a time; the two-entry queue holds later samples while it is busy.
// Reset (rst_ni, async low) clears channel, hold and peak state, queue and
// output valid; registers return to their documented defaults.
module soft_knee_peak_limiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] sample_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] sample_out_o,
  output logic        channel_index_o
);

  skpl_pkg::cfg_t  cfg_q;
  skpl_pkg::item_t f_item, q_item;
  logic            push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.gain_factor   <= 20'd65536;
      cfg_q.threshold_db  <= -16'sd256;
      cfg_q.knee_width_db <= 13'd1280;
      cfg_q.knee_scale    <= 16'd1638;
      cfg_q.attack_coef   <= 24'd16707424;
      cfg_q.release_coef  <= 24'd16773720;
      cfg_q.stereo_mode   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (skpl_pkg::cfg_idx_e'(cfg_idx_i))
        skpl_pkg::CFG_ENABLE:  cfg_q.enable        <= cfg_data_i[0];
        skpl_pkg::CFG_GAIN:    cfg_q.gain_factor   <= cfg_data_i[19:0];
        skpl_pkg::CFG_THRESH:  cfg_q.threshold_db  <= $signed(cfg_data_i[15:0]);
        skpl_pkg::CFG_KNEE_W:  cfg_q.knee_width_db <= cfg_data_i[12:0];
        skpl_pkg::CFG_KNEE_S:  cfg_q.knee_scale    <= cfg_data_i[15:0];
        skpl_pkg::CFG_ATTACK:  cfg_q.attack_coef   <= cfg_data_i;
        skpl_pkg::CFG_RELEASE: cfg_q.release_coef  <= cfg_data_i;
        skpl_pkg::CFG_STEREO:  cfg_q.stereo_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  skpl_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_stall_o, .sample_in_i,
    .full_i(full), .push_o(push), .item_o(f_item)
  );

  skpl_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .pop_i(pop),
    .item_o(q_item), .full_o(full), .empty_o(empty)
  );

  skpl_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .sample_out_o, .channel_index_o
  );

endmodule
